// ===== sv/lseg_pkg.sv =====
package lseg_pkg;

	localparam int TIME_W     = 32;
	localparam int PERIOD_W   = 14;
	localparam int ARG_W      = 6;
	localparam int LEVEL_W    = 5;
	localparam int IDX_W      = 6;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// register indexes on the write port
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ARG    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd5;

	// effect codes; the remaining codes of the field give no results
	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALL_ON = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ONE_ON = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHASE  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_STROBE = 3'd4;

	localparam logic [MODE_W-1:0]   MODE_RST   = MODE_OFF;
	localparam logic [PERIOD_W-1:0] PERIOD_RST = 14'd2000;
	localparam logic [ARG_W-1:0]    ARG_RST    = 6'd5;
	localparam logic [LEVEL_W-1:0]  LEVEL_RST  = 5'd31;
	localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = 5'd31;

	typedef struct packed {
		logic [LEVEL_W-1:0] red;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} rgb_t;

endpackage

// ===== sv/lseg_if.sv =====
interface lseg_stamp_if import lseg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, output time_ms, input ready);
	modport sink (input valid, input time_ms, output ready);
endinterface

interface lseg_pixel_if import lseg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   led_index;
	logic [LEVEL_W-1:0] red_out;
	logic [LEVEL_W-1:0] green_out;
	logic [LEVEL_W-1:0] blue_out;
	logic               last_led;

	modport source (output valid, output led_index, output red_out, output green_out,
		output blue_out, output last_led, input ready);
	modport sink (input valid, input led_index, input red_out, input green_out,
		input blue_out, input last_led, output ready);
endinterface

// ===== sv/led_strip_effect_generator.sv =====
// LED strip effect generator.
// stamp: one transaction per millisecond time stamp. pixel: one transaction per LED colour,
// lowest LED first, last_led set on the final colour of a stamp. Effects and levels are
// set through the write port (wr_en, wr_index, wr_data); the user must do so while the
// block is idle; the block does not enforce it. A stamp passes a 12-stage front pipeline:
// eight stages of 4-bit restoring modulo for the phase, one stage for phase and strobe, one
// for the products, and two stages of 3-bit restoring division by the period. The LED
// sequencer issues one LED per cycle, unless stalled, into a 3-stage colour pipeline (chase
// offset and products, then two stages of division by the ramp length). Throughput: one
// colour per cycle unless stalled. A stamp occupies the sequencer for all LED_COUNT LEDs in
// the off, all-on, chase and strobe effects, for at most one LED in one-on, and for none in
// the unused codes; the sequencer is what sets the sustained stamp rate. The front pipeline
// takes a stamp in every cycle while it has room, so stamps queue there during a walk.
// Reset clears every valid bit and the sequencer and loads the register defaults.
// When the receiver holds ready low the colour pipeline and then the front pipeline fill
// and hold their contents; stamp.ready drops once the first stage can no longer move.
module led_strip_effect_generator import lseg_pkg::*; #(
	parameter int LED_COUNT = 43
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	lseg_stamp_if.sink            stamp,
	lseg_pixel_if.source          pixel
);

	localparam int MOD_BITS   = 4;
	localparam int MOD_STAGES = TIME_W / MOD_BITS;
	localparam int NUM_W      = PERIOD_W + IDX_W;
	localparam int QUO_W      = IDX_W;
	localparam int QUO_SPLIT  = QUO_W / 2;
	localparam int CH_W       = LEVEL_W + ARG_W;
	localparam int CH_SPLIT   = 3;
	localparam int CHASE_W    = 8;
	localparam int CNT_W      = IDX_W + 1;
	localparam int NUMS       = 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam logic [CNT_W-1:0] COUNT_X  = CNT_W'(LED_COUNT);

	function automatic logic [PERIOD_W-1:0] mod_step(input logic [PERIOD_W-1:0] r,
		input logic b, input logic [PERIOD_W-1:0] d);
		logic [PERIOD_W:0] x;
		x = {r, b};
		if (x >= {1'b0, d})
			x = x - {1'b0, d};
		return x[PERIOD_W-1:0];
	endfunction

	function automatic logic [LEVEL_W-1:0] sat_level(input logic [QUO_W-1:0] q);
		return (q > QUO_W'(LEVEL_MAX)) ? LEVEL_MAX : q[LEVEL_W-1:0];
	endfunction

	// configuration registers
	logic [MODE_W-1:0]   mode_q;
	logic [PERIOD_W-1:0] period_q;
	logic [ARG_W-1:0]    arg_q;
	rgb_t                level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RST;
			period_q <= PERIOD_RST;
			arg_q    <= ARG_RST;
			level_q  <= '{red: LEVEL_RST, green: LEVEL_RST, blue: LEVEL_RST};
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:   mode_q        <= wr_data[MODE_W-1:0];
				REG_PERIOD: period_q      <= wr_data[PERIOD_W-1:0];
				REG_ARG:    arg_q         <= wr_data[ARG_W-1:0];
				REG_RED:    level_q.red   <= wr_data[LEVEL_W-1:0];
				REG_GREEN:  level_q.green <= wr_data[LEVEL_W-1:0];
				REG_BLUE:   level_q.blue  <= wr_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// stall chain, from the output back to the stamp channel
	logic l3_v_s, l2_v_s, l1_v_s;
	logic l3_room, l2_room, l1_room;
	logic dv2_v_s, dv1_v_s, mu_v_s, ph_v_s;
	logic dv2_room, dv1_room, mu_room, ph_room;
	logic seq_room, done_now;
	logic [MOD_STAGES-1:0] md_v_s, md_room, md_in_v;

	assign l3_room  = !l3_v_s || pixel.ready;
	assign l2_room  = !l2_v_s || l3_room;
	assign l1_room  = !l1_v_s || l2_room;
	assign dv2_room = !dv2_v_s || seq_room;
	assign dv1_room = !dv1_v_s || dv2_room;
	assign mu_room  = !mu_v_s || dv1_room;
	assign ph_room  = !ph_v_s || mu_room;

	always_comb begin
		md_room[MOD_STAGES-1] = !md_v_s[MOD_STAGES-1] || ph_room;
		for (int k = MOD_STAGES - 2; k >= 0; k--)
			md_room[k] = !md_v_s[k] || md_room[k+1];
	end

	assign stamp.ready = md_room[0];

	// phase: time stamp modulo period, four bits a stage
	logic [TIME_W-1:0]   md_ts_s   [MOD_STAGES-1];
	logic [PERIOD_W-1:0] md_rem_s  [MOD_STAGES];
	logic [TIME_W-1:0]   md_in_ts  [MOD_STAGES];
	logic [PERIOD_W-1:0] md_in_rem [MOD_STAGES];
	logic [PERIOD_W-1:0] md_nx_rem [MOD_STAGES];

	assign md_in_v = {md_v_s[MOD_STAGES-2:0], stamp.valid};

	always_comb begin
		logic [PERIOD_W-1:0] r;
		md_in_ts[0]  = stamp.time_ms;
		md_in_rem[0] = '0;
		for (int k = 1; k < MOD_STAGES; k++) begin
			md_in_ts[k]  = md_ts_s[k-1];
			md_in_rem[k] = md_rem_s[k-1];
		end
		for (int k = 0; k < MOD_STAGES; k++) begin
			r = md_in_rem[k];
			for (int j = 0; j < MOD_BITS; j++)
				r = mod_step(r, md_in_ts[k][TIME_W-1-j], period_q);
			md_nx_rem[k] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_v_s <= '0;
		end else begin
			for (int k = 0; k < MOD_STAGES; k++)
				if (md_room[k])
					md_v_s[k] <= md_in_v[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MOD_STAGES; k++)
			if (md_room[k] && md_in_v[k]) begin
				md_rem_s[k] <= md_nx_rem[k];
				if (k < MOD_STAGES - 1)
					md_ts_s[k] <= md_in_ts[k] << MOD_BITS;
			end
	end

	// phase fix-up and strobe
	logic [PERIOD_W-1:0] ph_phase_s, ph_strobe_s;
	logic [PERIOD_W-1:0] ph_phase, ph_strobe;

	always_comb begin
		ph_phase  = (period_q != '0) ? md_rem_s[MOD_STAGES-1] : PERIOD_W'(1);
		ph_strobe = (ph_phase < (period_q >> 1)) ? ph_phase : period_q - ph_phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ph_v_s <= 1'b0;
		else if (ph_room)
			ph_v_s <= md_v_s[MOD_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (ph_room && md_v_s[MOD_STAGES-1]) begin
			ph_phase_s  <= ph_phase;
			ph_strobe_s <= ph_strobe;
		end
	end

	// numerators: chase offset first, then strobe red, green, blue
	logic [NUM_W-1:0] mu_num_s [NUMS];
	logic [NUM_W-1:0] mu_num   [NUMS];
	logic [NUM_W-1:0] strobe2;

	always_comb begin
		strobe2   = NUM_W'({ph_strobe_s, 1'b0});
		mu_num[0] = NUM_W'(LED_COUNT) * NUM_W'(ph_phase_s);
		mu_num[1] = NUM_W'(level_q.red) * strobe2;
		mu_num[2] = NUM_W'(level_q.green) * strobe2;
		mu_num[3] = NUM_W'(level_q.blue) * strobe2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mu_v_s <= 1'b0;
		else if (mu_room)
			mu_v_s <= ph_v_s;
	end

	always_ff @(posedge clk) begin
		if (mu_room && ph_v_s)
			mu_num_s <= mu_num;
	end

	// division by the period, quotient below 2^QUO_W in every lane
	logic [NUM_W-1:0] dv1_rem_s [NUMS];
	logic [QUO_W-1:0] dv1_quo_s [NUMS];
	logic [NUM_W-1:0] dv1_rem   [NUMS];
	logic [QUO_W-1:0] dv1_quo   [NUMS];
	logic [QUO_W-1:0] dv2_quo   [NUMS];
	logic [IDX_W-1:0] dv2_offset_s, dv2_offset;
	rgb_t             dv2_rgb_s, dv2_rgb;

	always_comb begin
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] d;
		logic [QUO_W-1:0] q;
		for (int n = 0; n < NUMS; n++) begin
			r = mu_num_s[n];
			q = '0;
			for (int j = 0; j < QUO_W - QUO_SPLIT; j++) begin
				d = NUM_W'(period_q) << (QUO_W - 1 - j);
				if (r >= d) begin
					r = r - d;
					q[QUO_W-1-j] = 1'b1;
				end
			end
			dv1_rem[n] = r;
			dv1_quo[n] = q;
		end
	end

	always_comb begin
		logic [NUM_W-1:0] r;
		logic [NUM_W-1:0] d;
		logic [QUO_W-1:0] q;
		for (int n = 0; n < NUMS; n++) begin
			r = dv1_rem_s[n];
			q = dv1_quo_s[n];
			for (int j = QUO_W - QUO_SPLIT; j < QUO_W; j++) begin
				d = NUM_W'(period_q) << (QUO_W - 1 - j);
				if (r >= d) begin
					r = r - d;
					q[QUO_W-1-j] = 1'b1;
				end
			end
			dv2_quo[n] = q;
		end
		// a zero period divides to zero
		if (period_q == '0) begin
			dv2_offset = '0;
			dv2_rgb    = '0;
		end else begin
			dv2_offset    = dv2_quo[0];
			dv2_rgb.red   = sat_level(dv2_quo[1]);
			dv2_rgb.green = sat_level(dv2_quo[2]);
			dv2_rgb.blue  = sat_level(dv2_quo[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv1_v_s <= 1'b0;
			dv2_v_s <= 1'b0;
		end else begin
			if (dv1_room)
				dv1_v_s <= mu_v_s;
			if (dv2_room)
				dv2_v_s <= dv1_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (dv1_room && mu_v_s) begin
			dv1_rem_s <= dv1_rem;
			dv1_quo_s <= dv1_quo;
		end
		if (dv2_room && dv1_v_s) begin
			dv2_offset_s <= dv2_offset;
			dv2_rgb_s    <= dv2_rgb;
		end
	end

	// LED sequencer: holds one stamp and walks its LEDs
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] item_offset_q;
	rgb_t             item_rgb_q;
	logic             iss_v, iss_last, iss_done;
	logic [IDX_W-1:0] iss_idx;

	always_comb begin
		iss_v    = 1'b0;
		iss_idx  = idx_q;
		iss_last = (idx_q == LAST_IDX);
		iss_done = 1'b1;
		unique case (mode_q)
			MODE_OFF, MODE_ALL_ON, MODE_CHASE, MODE_STROBE: begin
				iss_v    = busy_q;
				iss_done = iss_last;
			end
			MODE_ONE_ON: begin
				iss_v    = busy_q && ({1'b0, arg_q} < COUNT_X);
				iss_idx  = arg_q;
				iss_last = 1'b1;
			end
			default: ;
		endcase
	end

	assign done_now = busy_q && iss_done && (!iss_v || l1_room);
	assign seq_room = !busy_q || done_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (seq_room) begin
			busy_q <= dv2_v_s;
			idx_q  <= '0;
		end else if (iss_v && l1_room) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_room && dv2_v_s) begin
			item_offset_q <= dv2_offset_s;
			item_rgb_q    <= dv2_rgb_s;
		end
	end

	// colour pipeline, stage 1: chase position and ramp products
	logic [IDX_W-1:0]   l1_idx_s, l2_idx_s, l3_idx_s;
	logic               l1_last_s, l2_last_s, l3_last_s;
	logic               l1_div_s, l2_div_s;
	rgb_t               l1_rgb_s, l2_rgb_s, l3_rgb_s;
	logic [CH_W-1:0]    l1_num_s [3];
	logic [CH_W-1:0]    l2_rem_s [3];
	logic [LEVEL_W-1:0] l2_quo_s [3];
	logic [CHASE_W-1:0] l1_chase;
	logic               l1_div;
	rgb_t               l1_rgb;
	logic [CH_W-1:0]    l1_num [3];
	logic [CH_W-1:0]    l2_rem [3];
	logic [LEVEL_W-1:0] l2_quo [3];
	logic [LEVEL_W-1:0] l3_quo [3];
	rgb_t               l3_rgb;

	always_comb begin
		l1_chase = CHASE_W'(iss_idx) - CHASE_W'(item_offset_q);
		// a zero ramp length divides to zero, which the direct colour already gives
		l1_div   = (mode_q == MODE_CHASE) && (l1_chase <= CHASE_W'(arg_q)) && (arg_q != '0);
		unique case (mode_q)
			MODE_ALL_ON, MODE_ONE_ON: l1_rgb = level_q;
			MODE_STROBE:              l1_rgb = item_rgb_q;
			default:                  l1_rgb = '0;
		endcase
		l1_num[0] = CH_W'(level_q.red) * CH_W'(l1_chase[ARG_W-1:0]);
		l1_num[1] = CH_W'(level_q.green) * CH_W'(l1_chase[ARG_W-1:0]);
		l1_num[2] = CH_W'(level_q.blue) * CH_W'(l1_chase[ARG_W-1:0]);
	end

	// stages 2 and 3: divide by the ramp length, quotient fits a level
	always_comb begin
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    d;
		logic [LEVEL_W-1:0] q;
		for (int n = 0; n < 3; n++) begin
			r = l1_num_s[n];
			q = '0;
			for (int j = 0; j < CH_SPLIT; j++) begin
				d = CH_W'(arg_q) << (LEVEL_W - 1 - j);
				if (r >= d) begin
					r = r - d;
					q[LEVEL_W-1-j] = 1'b1;
				end
			end
			l2_rem[n] = r;
			l2_quo[n] = q;
		end
	end

	always_comb begin
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    d;
		logic [LEVEL_W-1:0] q;
		for (int n = 0; n < 3; n++) begin
			r = l2_rem_s[n];
			q = l2_quo_s[n];
			for (int j = CH_SPLIT; j < LEVEL_W; j++) begin
				d = CH_W'(arg_q) << (LEVEL_W - 1 - j);
				if (r >= d) begin
					r = r - d;
					q[LEVEL_W-1-j] = 1'b1;
				end
			end
			l3_quo[n] = q;
		end
		if (l2_div_s)
			l3_rgb = '{red: l3_quo[0], green: l3_quo[1], blue: l3_quo[2]};
		else
			l3_rgb = l2_rgb_s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_v_s <= 1'b0;
			l2_v_s <= 1'b0;
			l3_v_s <= 1'b0;
		end else begin
			if (l1_room)
				l1_v_s <= iss_v;
			if (l2_room)
				l2_v_s <= l1_v_s;
			if (l3_room)
				l3_v_s <= l2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (l1_room && iss_v) begin
			l1_idx_s  <= iss_idx;
			l1_last_s <= iss_last;
			l1_div_s  <= l1_div;
			l1_rgb_s  <= l1_rgb;
			l1_num_s  <= l1_num;
		end
		if (l2_room && l1_v_s) begin
			l2_idx_s  <= l1_idx_s;
			l2_last_s <= l1_last_s;
			l2_div_s  <= l1_div_s;
			l2_rgb_s  <= l1_rgb_s;
			l2_rem_s  <= l2_rem;
			l2_quo_s  <= l2_quo;
		end
		if (l3_room && l2_v_s) begin
			l3_idx_s  <= l2_idx_s;
			l3_last_s <= l2_last_s;
			l3_rgb_s  <= l3_rgb;
		end
	end

	assign pixel.valid     = l3_v_s;
	assign pixel.led_index = l3_idx_s;
	assign pixel.red_out   = l3_rgb_s.red;
	assign pixel.green_out = l3_rgb_s.green;
	assign pixel.blue_out  = l3_rgb_s.blue;
	assign pixel.last_led  = l3_last_s;

endmodule

// ===== sv/lseg_checker.sv =====
module lseg_checker import lseg_pkg::*; #(
	parameter int LED_COUNT = 43
) (
	input logic               clk,
	input logic               arst_n,
	input logic               pixel_valid,
	input logic               pixel_ready,
	input logic [IDX_W-1:0]   led_index,
	input logic [LEVEL_W-1:0] red_out,
	input logic [LEVEL_W-1:0] green_out,
	input logic [LEVEL_W-1:0] blue_out,
	input logic               last_led
);

	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0] COUNT_X  = CNT_W'(LED_COUNT);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

	// track the previous colour of a stamp that is still running
	logic             chain_q;
	logic [IDX_W-1:0] prev_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chain_q <= 1'b0;
		else if (pixel_valid && pixel_ready)
			chain_q <= !last_led;
	end

	always_ff @(posedge clk) begin
		if (pixel_valid && pixel_ready)
			prev_idx_q <= led_index;
	end

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid
			&& $stable({led_index, red_out, green_out, blue_out, last_led}))
		else $error("colour changed while stalled");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> ({1'b0, led_index} < COUNT_X))
		else $error("LED index beyond the strip");

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && chain_q |-> led_index == prev_idx_q + 1'b1)
		else $error("LED skipped or repeated within a stamp");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (led_index == LAST_IDX) |-> last_led)
		else $error("final LED not marked last");

endmodule

bind led_strip_effect_generator lseg_checker #(.LED_COUNT(LED_COUNT)) u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pixel_valid (pixel.valid),
	.pixel_ready (pixel.ready),
	.led_index   (pixel.led_index),
	.red_out     (pixel.red_out),
	.green_out   (pixel.green_out),
	.blue_out    (pixel.blue_out),
	.last_led    (pixel.last_led)
);
